// ===== src/fvn_pkg.sv =====
package fvn_pkg;

  localparam int OCT_W = 4;
  localparam int CNT_W = 5;
  localparam int LANES = 8;
  localparam int ENG_DEPTH = 7;

  localparam logic [31:0] HASH_MX   = 32'd374761393;
  localparam logic [31:0] HASH_MY   = 32'd668265263;
  localparam logic [31:0] HASH_MZ   = 32'd2147483647;
  localparam logic [31:0] HASH_K1   = 32'd1274126177;
  localparam logic [31:0] HASH_K2   = 32'h7feb352d;
  localparam logic [31:0] HASH_K3   = 32'h846ca68b;
  localparam logic [31:0] SEED_STEP = 32'd1013;
  localparam logic signed [18:0] SCALE_Q16 = 19'sd133038;
  localparam logic [17:0] FADE_K = 18'd196608;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_MUL,
    ST_FIN
  } fvn_state_t;

  typedef struct packed {
    logic             valid;
    logic [OCT_W-1:0] oct;
  } oct_req_t;

  // 2^k/(2^k-1) in Q2.30
  function automatic logic [31:0] recip_q30(input logic [CNT_W-1:0] k);
    logic [31:0] r;
    unique case (k)
      5'd1:    r = 32'd2147483648;
      5'd2:    r = 32'd1431655765;
      5'd3:    r = 32'd1227133513;
      5'd4:    r = 32'd1145324612;
      5'd5:    r = 32'd1108378657;
      5'd6:    r = 32'd1090785345;
      5'd7:    r = 32'd1082196484;
      5'd8:    r = 32'd1077952576;
      5'd9:    r = 32'd1075843080;
      5'd10:   r = 32'd1074791425;
      5'd11:   r = 32'd1074266368;
      5'd12:   r = 32'd1074004032;
      5'd13:   r = 32'd1073872912;
      5'd14:   r = 32'd1073807364;
      5'd15:   r = 32'd1073774593;
      5'd16:   r = 32'd1073758208;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // a + floor((b - a) * f / 65536), equal to the two-term lerp
  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                        input logic [16:0] f);
    logic signed [16:0] diff;
    logic signed [34:0] pr;
    logic signed [18:0] s;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    pr   = diff * $signed({1'b0, f});
    s    = $signed({3'b000, a}) + $signed(pr[34:16]);
    return s[15:0];
  endfunction

endpackage

// ===== src/fvn_corner.sv =====
module fvn_corner
  import fvn_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] h_in,
  output logic [15:0] value
);

  logic [31:0] a, b1, b2, c, d;
  logic [31:0] r1_r, r2_r, r3_r;

  assign a  = h_in ^ (h_in >> 13);
  assign b1 = r1_r ^ (r1_r >> 16);
  assign b2 = b1 ^ (b1 >> 16);
  assign c  = r2_r ^ (r2_r >> 15);
  assign d  = r3_r ^ (r3_r >> 16);
  assign value = d[31:16];

  always_ff @(posedge clk) begin
    r1_r <= a * HASH_K1;
    r2_r <= b2 * HASH_K2;
    r3_r <= c * HASH_K3;
  end

endmodule

// ===== src/fvn_octave.sv =====
module fvn_octave
  import fvn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  oct_req_t    req,
  input  logic [31:0] p_x,
  input  logic [31:0] p_y,
  input  logic [31:0] p_z,
  input  logic [31:0] seed,
  output oct_req_t    res,
  output logic [15:0] nv,
  output logic        busy
);

  logic [31:0] cx0, cy0, cz0;
  logic [31:0] xm [2];
  logic [31:0] ym [2];
  logic [31:0] zm [2];
  logic [31:0] h0_nxt [LANES];
  logic [31:0] h0_r [LANES];
  logic [15:0] cval [LANES];
  logic [15:0] t_r [3];
  logic [15:0] t_d_r [3];
  logic [31:0] tt_r [3];
  logic [16:0] f_r [3];
  logic [16:0] f1_r [3];
  logic [16:0] f2_r [3];
  logic [16:0] f3_r [3];
  logic [15:0] ax_r [4];
  logic [15:0] ay_r [2];
  logic [15:0] nv_r;
  logic [ENG_DEPTH-1:0] v_r;
  logic [OCT_W-1:0] o_r [ENG_DEPTH];

  assign cx0 = {{16{p_x[31]}}, p_x[31:16]};
  assign cy0 = {{16{p_y[31]}}, p_y[31:16]};
  assign cz0 = {{16{p_z[31]}}, p_z[31:16]};

  always_comb begin
    xm[0] = cx0 * HASH_MX;
    xm[1] = (cx0 + 32'd1) * HASH_MX;
    ym[0] = cy0 * HASH_MY;
    ym[1] = (cy0 + 32'd1) * HASH_MY;
    zm[0] = cz0 * HASH_MZ;
    zm[1] = (cz0 + 32'd1) * HASH_MZ;
    for (int i = 0; i < LANES; i++) begin
      h0_nxt[i] = seed ^ xm[i % 2] ^ ym[(i / 2) % 2] ^ zm[i / 4];
    end
  end

  // corner lanes: bit 0 of the lane picks x, bit 1 y, bit 2 z
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    fvn_corner u_corner (
      .clk   (clk),
      .h_in  (h0_r[g]),
      .value (cval[g])
    );
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      h0_r[i] <= h0_nxt[i];
    end
    t_r[0] <= p_x[15:0];
    t_r[1] <= p_y[15:0];
    t_r[2] <= p_z[15:0];
    for (int i = 0; i < 3; i++) begin
      tt_r[i]  <= 32'(t_r[i] * t_r[i]);
      t_d_r[i] <= t_r[i];
      f_r[i]   <= 17'((50'(tt_r[i]) * 50'(FADE_K - {1'b0, t_d_r[i], 1'b0})) >> 32);
      f1_r[i]  <= f_r[i];
      f2_r[i]  <= f1_r[i];
      f3_r[i]  <= f2_r[i];
    end
    for (int j = 0; j < 4; j++) begin
      ax_r[j] <= blend(cval[2*j], cval[2*j+1], f1_r[0]);
    end
    ay_r[0] <= blend(ax_r[0], ax_r[1], f2_r[1]);
    ay_r[1] <= blend(ax_r[2], ax_r[3], f2_r[1]);
    nv_r    <= blend(ay_r[0], ay_r[1], f3_r[2]);
    o_r[0]  <= req.oct;
    for (int k = 1; k < ENG_DEPTH; k++) begin
      o_r[k] <= o_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[ENG_DEPTH-2:0], req.valid};
    end
  end

  assign res.valid = v_r[ENG_DEPTH-1];
  assign res.oct   = o_r[ENG_DEPTH-1];
  assign nv        = nv_r;
  assign busy      = |v_r;

endmodule

// ===== src/fractal_value_noise_3d_unit.sv =====
// The octave count is clamped to MAX_OCTAVES. A request is taken only while idle; its
// octaves issue one per cycle into a seven-stage octave engine with eight corner-hash
// lanes, then drain. A new request is taken in the cycle the result strobe is high;
// results cannot stall.
// Reset: synchronous, active low; clears the controller, engine valids and the strobe.
module fractal_value_noise_3d_unit
  import fvn_pkg::*;
#(
  parameter int MAX_OCTAVES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_dir_x,
  input  logic [15:0] in_dir_y,
  input  logic [15:0] in_dir_z,
  input  logic [13:0] in_frequency,
  input  logic [31:0] in_noise_seed,
  input  logic [3:0]  in_octave_count,
  input  logic        in_ridged,
  output logic        out_valid,
  output logic [15:0] out_noise_value
);

  fvn_state_t state_r, state_nxt;

  logic [31:0] p_r [3];
  logic [31:0] p_nxt [3];
  logic [31:0] p_init [3];
  logic signed [30:0] ip [3];
  logic signed [50:0] sp [3];
  logic [31:0] seed_r;
  logic [OCT_W-1:0] oct_r;
  logic [CNT_W-1:0] cnt_r, cnt_in;
  logic ridged_r;
  logic [31:0] acc_r;
  logic [63:0] prod_r;
  logic [17:0] rq;
  logic [16:0] nq;
  logic signed [18:0] fold;
  logic [16:0] fold_abs, rv;
  logic [15:0] res_val;
  logic out_valid_r, out_valid_nxt;
  logic [15:0] out_val_r;
  logic accept, issue, last_issue;
  oct_req_t eng_req, eng_res;
  logic [15:0] eng_nv;
  logic eng_busy;

  assign accept = start && (state_r == ST_IDLE);
  assign cnt_in = ({1'b0, in_octave_count} > CNT_W'(MAX_OCTAVES)) ?
                  CNT_W'(MAX_OCTAVES) : {1'b0, in_octave_count};
  assign last_issue = ({1'b0, oct_r} == (cnt_r - CNT_W'(1)));

  always_comb begin
    ip[0] = $signed(in_dir_x) * $signed({1'b0, in_frequency});
    ip[1] = $signed(in_dir_y) * $signed({1'b0, in_frequency});
    ip[2] = $signed(in_dir_z) * $signed({1'b0, in_frequency});
    for (int i = 0; i < 3; i++) begin
      p_init[i] = {{7{ip[i][30]}}, ip[i][30:6]};
      sp[i]     = $signed(p_r[i]) * SCALE_Q16;
      p_nxt[i]  = sp[i][47:16];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (cnt_in == '0) ? ST_DRAIN : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!eng_busy) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    issue         = 1'b0;
    busy          = 1'b1;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE:  busy = 1'b0;
      ST_ISSUE: issue = 1'b1;
      ST_FIN:   out_valid_nxt = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign eng_req.valid = issue;
  assign eng_req.oct   = oct_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= p_init[i];
      end
      seed_r   <= in_noise_seed;
      oct_r    <= '0;
      cnt_r    <= cnt_in;
      ridged_r <= in_ridged;
      acc_r    <= '0;
    end else begin
      if (issue) begin
        for (int i = 0; i < 3; i++) begin
          p_r[i] <= p_nxt[i];
        end
        seed_r <= seed_r + SEED_STEP;
        oct_r  <= oct_r + OCT_W'(1);
      end
      if (eng_res.valid) begin
        acc_r <= acc_r + ({16'd0, eng_nv} << (OCT_W'(15) - eng_res.oct));
      end
    end
    if (state_r == ST_MUL) begin
      prod_r <= 64'(acc_r) * 64'(recip_q30(cnt_r));
    end
    if (out_valid_nxt) begin
      out_val_r <= res_val;
    end
  end

  // normalize, clamp to 1.0, optional ridged fold, saturate
  always_comb begin
    rq       = prod_r[63:46];
    nq       = (rq > 18'(ONE_Q16)) ? ONE_Q16 : rq[16:0];
    fold     = $signed({1'b0, nq, 1'b0}) - $signed({2'b00, ONE_Q16});
    fold_abs = fold[18] ? 17'(-fold) : fold[16:0];
    rv       = ridged_r ? (ONE_Q16 - fold_abs) : nq;
    res_val  = rv[16] ? 16'hFFFF : rv[15:0];
  end

  fvn_octave u_octave (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (eng_req),
    .p_x   (p_r[0]),
    .p_y   (p_r[1]),
    .p_z   (p_r[2]),
    .seed  (seed_r),
    .res   (eng_res),
    .nv    (eng_nv),
    .busy  (eng_busy)
  );

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_val_r;

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");
  a_engine_window: assert property (@(posedge clk) disable iff (!rst_n)
    eng_res.valid |-> (state_r == ST_ISSUE || state_r == ST_DRAIN))
    else $error("octave result outside accumulation window");
  a_mul_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> !eng_busy)
    else $error("normalize started before engine drained");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");
`endif

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_OCT = 8;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_dir_x = '0;
  logic [15:0] in_dir_y = '0;
  logic [15:0] in_dir_z = '0;
  logic [13:0] in_frequency = '0;
  logic [31:0] in_noise_seed = '0;
  logic [3:0]  in_octave_count = '0;
  logic        in_ridged = 1'b0;
  logic        out_valid;
  logic [15:0] out_noise_value;

  logic [15:0] noise_due[$];
  int          err_count = 0;
  int          cycle_count = 0;
  bit          quiet_tail = 1'b0;

  fractal_value_noise_3d_unit #(.MAX_OCTAVES(MAX_OCT)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .in_frequency(in_frequency), .in_noise_seed(in_noise_seed),
    .in_octave_count(in_octave_count), .in_ridged(in_ridged),
    .out_valid(out_valid), .out_noise_value(out_noise_value)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] lattice_hash(logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z, logic [31:0] seed);
    logic [31:0] h;
    h = seed ^ (x * 32'd374761393);
    h = h ^ (y * 32'd668265263);
    h = h ^ (z * 32'd2147483647);
    h = h ^ (h >> 13);
    h = h * 32'd1274126177;
    h = h ^ (h >> 16);
    h = h ^ (h >> 16);
    h = h * 32'h7feb352d;
    h = h ^ (h >> 15);
    h = h * 32'h846ca68b;
    h = h ^ (h >> 16);
    return h >> 16;
  endfunction

  function automatic logic [31:0] smooth_fade(logic [31:0] t);
    logic [63:0] tt;
    tt = 64'(t) * 64'(t);
    tt = tt * (64'd196608 - 64'd2 * 64'(t));
    return tt[63:32];
  endfunction

  function automatic logic [31:0] mix(logic [31:0] a, logic [31:0] b, logic [31:0] t);
    logic [63:0] s;
    s = 64'(a) * (64'd65536 - 64'(t)) + 64'(b) * 64'(t);
    return s[47:16];
  endfunction

  function automatic logic [31:0] octave_noise(logic [31:0] px, logic [31:0] py,
                                               logic [31:0] pz, logic [31:0] seed);
    logic [31:0] x0, y0, z0, x1, y1, z1, fx, fy, fz, a00, a10, a01, a11;
    x0 = 32'($signed(px) >>> 16);
    y0 = 32'($signed(py) >>> 16);
    z0 = 32'($signed(pz) >>> 16);
    x1 = x0 + 1; y1 = y0 + 1; z1 = z0 + 1;
    fx = smooth_fade({16'd0, px[15:0]});
    fy = smooth_fade({16'd0, py[15:0]});
    fz = smooth_fade({16'd0, pz[15:0]});
    a00 = mix(lattice_hash(x0, y0, z0, seed), lattice_hash(x1, y0, z0, seed), fx);
    a10 = mix(lattice_hash(x0, y1, z0, seed), lattice_hash(x1, y1, z0, seed), fx);
    a01 = mix(lattice_hash(x0, y0, z1, seed), lattice_hash(x1, y0, z1, seed), fx);
    a11 = mix(lattice_hash(x0, y1, z1, seed), lattice_hash(x1, y1, z1, seed), fx);
    return mix(mix(a00, a10, fy), mix(a01, a11, fy), fz);
  endfunction

  function automatic logic [15:0] fbm_predict(logic [15:0] dx, logic [15:0] dy,
                                              logic [15:0] dz, logic [13:0] freq,
                                              logic [31:0] seed, logic [3:0] cnt,
                                              logic ridge);
    logic [31:0]  norm_q30 [0:16] = '{32'd0, 32'd2147483648, 32'd1431655765,
      32'd1227133513, 32'd1145324612, 32'd1108378657, 32'd1090785345, 32'd1082196484,
      32'd1077952576, 32'd1075843080, 32'd1074791425, 32'd1074266368, 32'd1074004032,
      32'd1073872912, 32'd1073807364, 32'd1073774593, 32'd1073758208};
    logic signed [63:0] pt [3];
    logic [15:0]  dv [3];
    logic [63:0]  acc;
    logic [127:0] r;
    logic signed [63:0] d;
    int k, n;
    dv[0] = dx; dv[1] = dy; dv[2] = dz;
    k = (cnt > MAX_OCT) ? MAX_OCT : cnt;
    acc = 0;
    n = 0;
    for (int i = 0; i < 3; i++)
      pt[i] = 64'(32'((64'($signed(dv[i])) * 64'(freq)) >>> 6));
    for (int o = 0; o < k; o++) begin
      acc += 64'(octave_noise(32'(pt[0]), 32'(pt[1]), 32'(pt[2]),
                              seed + 32'(o) * 32'd1013)) << (15 - o);
      for (int i = 0; i < 3; i++)
        pt[i] = 64'(32'((64'($signed(32'(pt[i]))) * 64'sd133038) >>> 16));
    end
    if (k > 0) begin
      r = (128'(acc) * 128'(norm_q30[k])) >> 46;
      n = (r > 65536) ? 65536 : int'(r);
    end
    if (ridge) begin
      d = 2 * n - 65536;
      if (d < 0) d = -d;
      d = 65536 - d;
      n = (d < 0) ? 0 : int'(d);
    end
    if (n > 65535) n = 65535;
    return 16'(n);
  endfunction

  // Result checker
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      if (noise_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time,
                 out_noise_value);
        err_count++;
      end else begin
        logic [15:0] want;
        want = noise_due.pop_front();
        if (out_noise_value !== want) begin
          $display("%0t: noise_value mismatch, expected %0d, actual %0d", $time,
                   want, out_noise_value);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // start stays high after the accept until the next request or an explicit drop;
  // busy keeps the held request from being taken twice
  task automatic send_request(logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                              logic [13:0] freq, logic [31:0] seed, logic [3:0] cnt,
                              logic ridge);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_dir_x <= dx; in_dir_y <= dy; in_dir_z <= dz;
    in_frequency <= freq; in_noise_seed <= seed;
    in_octave_count <= cnt; in_ridged <= ridge;
    @(posedge clk);
    while (busy) @(posedge clk);
    noise_due.push_back(fbm_predict(dx, dy, dz, freq, seed, cnt, ridge));
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_dir();
    int v;
    v = $urandom_range(0, 32768);
    return 16'(v - 16384);
  endfunction

  task automatic test_extremes();
    send_request(16'sd16384, 16'sd16384, 16'sd16384, 14'd16383, 32'hFFFFFFFF, 4'd8, 1'b0);
    send_request(-16'sd16384, -16'sd16384, -16'sd16384, 14'd16383, 32'd0, 4'd8, 1'b1);
    send_request(16'd0, 16'd0, 16'd0, 14'd0, 32'd0, 4'd0, 1'b0);
    send_request(16'd0, 16'd0, 16'd0, 14'd0, 32'd0, 4'd0, 1'b1);
    send_request(16'd100, -16'sd200, 16'd300, 14'd256, 32'h12345678, 4'd1, 1'b0);
    send_request(16'd100, -16'sd200, 16'd300, 14'd256, 32'h12345678, 4'd1, 1'b1);
  endtask

  task automatic test_octave_counts();
    // counts above the maximum clamp
    for (int c = 0; c < 16; c++)
      send_request(rand_dir(), rand_dir(), rand_dir(), 14'($urandom), $urandom,
                   4'(c), 1'($urandom));
  endtask

  task automatic test_drain_pause();
    start <= 1'b0;
    while (noise_due.size() != 0) @(negedge clk);
    send_request(16'sd8192, -16'sd8192, 16'sd11585, 14'd1024, $urandom, 4'd8, 1'b0);
  endtask

  task automatic test_random(int count);
    logic [15:0] d [3];
    for (int i = 0; i < count; i++) begin
      for (int j = 0; j < 3; j++)
        d[j] = ($urandom_range(0, 9) == 0) ? 16'($urandom) : rand_dir();
      send_request(d[0], d[1], d[2], 14'($urandom), $urandom,
                   ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8)),
                   1'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_octave_counts();
    test_drain_pause();
    test_random(500);
    quiet_tail = 1'b1;
    test_random(80);
    @(negedge clk);
    start <= 1'b0;
    while (noise_due.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
